FILE: sv/olst_pkg.sv
`default_nettype none

package olst_pkg;

    // list depth, valid range 2 to 64
    localparam int unsigned Capacity = 16;
    localparam int unsigned CntW     = $clog2(Capacity + 1);
    localparam int unsigned IdxW     = $clog2(Capacity);

    // operation codes
    localparam logic [2:0] FUNC_APPEND = 3'd0;
    localparam logic [2:0] FUNC_DELETE = 3'd1;
    localparam logic [2:0] FUNC_MODIFY = 3'd2;
    localparam logic [2:0] FUNC_SORT   = 3'd3;
    localparam logic [2:0] FUNC_READ   = 3'd4;
    localparam logic [2:0] FUNC_CLEAR  = 3'd5;

    // status codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] value;
        logic signed [31:0] new_value;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] element;
        logic               last;
    } t_out;

    // control broadcast along the cell row
    typedef struct packed {
        logic               shift;  // every cell takes its right neighbor
        logic               we;     // one cell loads wdata
        logic [IdxW-1:0]    widx;
        logic signed [31:0] wdata;
    } t_chain_ctl;

endpackage

`default_nettype wire

FILE: sv/ordered_list_store_top.sv
`default_nettype none

// Ordered list of up to Capacity signed 32-bit values, held in a row of cells
// with the head in cell 0. Every operation but append and clear walks the list
// by rotating the row one place a cycle, read out only while the output is
// free: the head leaves cell 0, is compared or emitted, and goes back in at
// the tail (or is dropped by delete, or replaced by modify). One item is worked
// at a time. Append, clear, unused codes and the empty or too-short cases
// answer with a beat registered in the accept cycle. Read out gives one beat
// per element, delete and modify end with a status beat, and sort repeats
// bubble passes until a pass makes no swap. The output holds one registered
// beat; a new item is taken while that beat still waits as long as the
// downstream is ready in the same cycle. Stalls at the output only pause read
// out and the final status beat. Reset empties the list.

module ordered_list_store_top
    import olst_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_RUN       = 3'd1;
    localparam logic [2:0] S_SORT_HEAD = 3'd2;
    localparam logic [2:0] S_SORT_STEP = 3'd3;
    localparam logic [2:0] S_SORT_END  = 3'd4;
    localparam logic [2:0] S_FIN       = 3'd5;

    logic [2:0]         r_state, n_state;
    logic [CntW-1:0]    r_count, n_count;
    logic [CntW-1:0]    r_steps, n_steps;
    logic [2:0]         r_op, n_op;
    logic signed [31:0] r_value, n_value;
    logic signed [31:0] r_new, n_new;
    logic               r_found, n_found;
    logic signed [31:0] r_carry, n_carry;
    logic               r_swapped, n_swapped;
    logic               r_out_valid, n_out_valid;
    t_out               r_out, n_out;

    t_chain_ctl         w_ctl;
    logic signed [31:0] w_head;
    logic               w_in_fire;
    logic               w_out_free;
    logic               w_hit;
    logic               w_gt;
    logic [IdxW-1:0]    w_tail;    // last occupied slot
    logic [IdxW-1:0]    w_tail2;   // slot before it

    olst_chain u_chain (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .o_head (w_head)
    );

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_fire  = i_in_valid && o_in_ready;

    assign w_tail  = IdxW'(r_count - CntW'(1));
    assign w_tail2 = IdxW'(r_count - CntW'(2));
    assign w_hit   = !r_found && (w_head == r_value);
    assign w_gt    = r_carry > w_head;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_steps     = r_steps;
        n_op        = r_op;
        n_value     = r_value;
        n_new       = r_new;
        n_found     = r_found;
        n_carry     = r_carry;
        n_swapped   = r_swapped;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_ctl       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_op        = i_in_data.func;
                    n_value     = i_in_data.value;
                    n_new       = i_in_data.new_value;
                    n_found     = 1'b0;
                    n_out_valid = 1'b1;
                    n_out       = '{status: ST_DONE, element: '0, last: 1'b1};
                    case (i_in_data.func) inside
                        FUNC_APPEND: begin
                            if (r_count == CntW'(Capacity)) begin
                                n_out.status = ST_FULL;
                            end else begin
                                w_ctl.we    = 1'b1;
                                w_ctl.widx  = r_count[IdxW-1:0];
                                w_ctl.wdata = i_in_data.value;
                                n_count     = r_count + CntW'(1);
                            end
                        end
                        FUNC_DELETE, FUNC_MODIFY: begin
                            if (r_count == '0) begin
                                n_out.status = ST_NOTFOUND;
                            end else begin
                                n_out_valid = r_out_valid && !i_out_ready;
                                n_out       = r_out;
                                n_steps     = r_count;
                                n_state     = S_RUN;
                            end
                        end
                        FUNC_SORT: begin
                            if (r_count < CntW'(2)) begin
                                n_out.status = ST_EMPTY;
                            end else begin
                                n_out_valid = r_out_valid && !i_out_ready;
                                n_out       = r_out;
                                n_state     = S_SORT_HEAD;
                            end
                        end
                        FUNC_READ: begin
                            if (r_count == '0) begin
                                n_out.status = ST_EMPTY;
                            end else begin
                                n_out_valid = r_out_valid && !i_out_ready;
                                n_out       = r_out;
                                n_steps     = r_count;
                                n_state     = S_RUN;
                            end
                        end
                        FUNC_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // one rotation step: head out of cell 0, back in at the tail
            S_RUN: begin
                if (r_op != FUNC_READ || w_out_free) begin
                    w_ctl.shift = 1'b1;
                    w_ctl.widx  = w_tail;
                    w_ctl.wdata = w_head;
                    case (r_op)
                        FUNC_READ: begin
                            w_ctl.we    = 1'b1;
                            n_out_valid = 1'b1;
                            n_out       = '{status: ST_DONE, element: w_head,
                                            last: (r_steps == CntW'(1))};
                        end
                        FUNC_DELETE: begin
                            if (w_hit) begin
                                n_found = 1'b1;
                                n_count = r_count - CntW'(1);
                            end else begin
                                w_ctl.we = 1'b1;
                            end
                        end
                        default: begin
                            w_ctl.we = 1'b1;
                            if (w_hit) begin
                                w_ctl.wdata = r_new;
                                n_found     = 1'b1;
                            end
                        end
                    endcase
                    n_steps = r_steps - CntW'(1);
                    if (r_steps == CntW'(1)) begin
                        n_state = (r_op == FUNC_READ) ? S_IDLE : S_FIN;
                    end
                end
            end

            // start a bubble pass: first element becomes the carry
            S_SORT_HEAD: begin
                n_carry     = w_head;
                w_ctl.shift = 1'b1;
                n_steps     = r_count - CntW'(1);
                n_swapped   = 1'b0;
                n_state     = S_SORT_STEP;
            end

            // smaller of carry and head goes to the tail, larger rides on
            S_SORT_STEP: begin
                w_ctl.shift = 1'b1;
                w_ctl.we    = 1'b1;
                w_ctl.widx  = w_tail2;
                w_ctl.wdata = w_gt ? w_head : r_carry;
                n_carry     = w_gt ? r_carry : w_head;
                n_swapped   = r_swapped || w_gt;
                n_steps     = r_steps - CntW'(1);
                if (r_steps == CntW'(1)) begin
                    n_state = S_SORT_END;
                end
            end

            S_SORT_END: begin
                w_ctl.we    = 1'b1;
                w_ctl.widx  = w_tail;
                w_ctl.wdata = r_carry;
                if (r_swapped) begin
                    n_state = S_SORT_HEAD;
                end else begin
                    n_found = 1'b1;
                    n_state = S_FIN;
                end
            end

            S_FIN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{status: (r_found ? ST_DONE : ST_NOTFOUND),
                                    element: '0, last: 1'b1};
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_swapped   <= 1'b0;
            r_steps     <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_found     <= n_found;
            r_swapped   <= n_swapped;
            r_steps     <= n_steps;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_value <= n_value;
        r_new   <= n_new;
        r_carry <= n_carry;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

FILE: sv/olst_cell.sv
`default_nettype none

module olst_cell
    import olst_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_shift,
    input  wire logic               i_load,
    input  wire logic signed [31:0] i_wdata,
    input  wire logic signed [31:0] i_next,
    output logic signed [31:0]      o_data
);

    logic signed [31:0] r_data;

    // load wins over shift: the tail slot is written while the row moves
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_wdata;
        end else if (i_shift) begin
            r_data <= i_next;
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

FILE: sv/olst_chain.sv
`default_nettype none

module olst_chain
    import olst_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_chain_ctl  i_ctl,
    output logic signed [31:0] o_head
);

    logic signed [31:0] w_data [Capacity];

    for (genvar g = 0; g < Capacity; g++) begin : g_cell
        logic               w_load;
        logic signed [31:0] w_next;

        assign w_load = i_ctl.we && (i_ctl.widx == IdxW'(g));

        if (g == Capacity - 1) begin : g_end
            assign w_next = w_data[g];
        end else begin : g_mid
            assign w_next = w_data[g + 1];
        end

        olst_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (i_ctl.shift),
            .i_load  (w_load),
            .i_wdata (i_ctl.wdata),
            .i_next  (w_next),
            .o_data  (w_data[g])
        );
    end

    assign o_head = w_data[0];

endmodule

`default_nettype wire

FILE: dv/tb_ordered_list_store_top.sv
`default_nettype none

// Self-checking bench for the ordered list store.
// - A scoreboard object keeps its own copy of the list. Every input beat it
//   sees accepted produces the expected output beats, and every output beat
//   taken is checked against the oldest one still waiting.
// - The sender and the receiver both idle at random.
// - Twice the receiver holds off for a long stretch while the sender keeps
//   offering items, so the single output register fills up and the block
//   stalls its input.

module tb_ordered_list_store_top;
    timeunit 1ns;
    timeprecision 1ps;

    import olst_pkg::*;

    // func codes the block leaves unused; it answers them with a plain done beat
    localparam logic [2:0] FUNC_SPARE6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE7 = 3'd7;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    localparam int RAND_ITEMS     = 148;
    localparam int HOLD_CYCLES    = 150;  // long receiver hold-off
    // wait after the last expected beat, longer than the worst sort on a full list
    localparam int DRAIN_CYCLES   = 300;
    // hold-off + full sort + longest gap, taken several times over
    localparam int WATCHDOG_LIMIT = 4000;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    t_in  in_data;
    logic out_valid;
    logic out_ready;
    t_out out_data;

    bit   hold_now;     // main asks the receiver for a long hold-off
    bit   calm;         // no idling on either side while set
    int   idle_cycles;

    always #5 clk = ~clk;

    ordered_list_store_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // ------------------------------------------------------------------
    // Scoreboard: shadow list plus the queue of beats still to come
    // ------------------------------------------------------------------
    class list_scoreboard;
        logic signed [31:0] cells [Capacity];
        int                 fill;
        t_out               expected_beats [$];
        int                 errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function void push_beat(logic [1:0] st, logic signed [31:0] el, logic lst);
            t_out b;
            b.status  = st;
            b.element = el;
            b.last    = lst;
            expected_beats.push_back(b);
        endfunction

        // index of the first element equal to v, -1 if none
        function int find_index(logic signed [31:0] v);
            for (int i = 0; i < fill; i++) begin
                if (cells[i] == v) return i;
            end
            return -1;
        endfunction

        function void note_item(t_in it);
            logic [1:0]         st;
            int                 pos;
            int                 i;
            bit                 swapped;
            logic signed [31:0] tmp;
            st = ST_DONE;
            case (it.func)
                FUNC_APPEND: begin
                    if (fill >= Capacity) begin
                        st = ST_FULL;
                    end else begin
                        cells[fill] = it.value;
                        fill++;
                    end
                end
                FUNC_DELETE: begin
                    pos = find_index(it.value);
                    if (pos < 0) begin
                        st = ST_NOTFOUND;
                    end else begin
                        for (i = pos; i + 1 < fill; i++) cells[i] = cells[i + 1];
                        fill--;
                    end
                end
                FUNC_MODIFY: begin
                    pos = find_index(it.value);
                    if (pos < 0) st = ST_NOTFOUND;
                    else cells[pos] = it.new_value;
                end
                FUNC_SORT: begin
                    if (fill < 2) begin
                        st = ST_EMPTY;
                    end else begin
                        do begin
                            swapped = 1'b0;
                            for (i = 0; i + 1 < fill; i++) begin
                                if (cells[i] > cells[i + 1]) begin
                                    tmp          = cells[i];
                                    cells[i]     = cells[i + 1];
                                    cells[i + 1] = tmp;
                                    swapped      = 1'b1;
                                end
                            end
                        end while (swapped);
                    end
                end
                FUNC_READ: begin
                    if (fill == 0) begin
                        st = ST_EMPTY;
                    end else begin
                        // one beat per element, last mark on the tail
                        for (i = 0; i < fill; i++) push_beat(ST_DONE, cells[i], i + 1 == fill);
                        return;
                    end
                end
                FUNC_CLEAR: fill = 0;
                default: ;
            endcase
            push_beat(st, '0, 1'b1);
        endfunction

        function void check_beat(t_out got);
            t_out want;
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual status %0d element %0d last %0d",
                         $time, got.status, got.element, got.last);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.element !== want.element) begin
                $display("%0t: element mismatch, expected %0d, actual %0d",
                         $time, want.element, got.element);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last mismatch, expected %0d, actual %0d",
                         $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    list_scoreboard sb = new();

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // small values give duplicates, extremes hit the sign boundary
    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 3))
            0: return 32'($urandom_range(0, 15)) - 32'd8;
            1: begin
                case ($urandom_range(0, 3))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return '0;
                    default: return -32'sd1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // mostly an element that is in the list now, so the match path is taken
    function automatic logic signed [31:0] list_value();
        if (sb.fill > 0 && $urandom_range(0, 99) < 75) return sb.cells[$urandom_range(0, sb.fill - 1)];
        return rand_value();
    endfunction

    // ------------------------------------------------------------------
    // Sender: valid goes up after a random gap and stays up until the beat
    // is taken. Back-to-back items keep valid high.
    // ------------------------------------------------------------------
    task automatic send_op(input logic [2:0] f, input logic signed [31:0] v,
                           input logic signed [31:0] nv);
        int   gap;
        t_in  it;
        it.func      = f;
        it.value     = v;
        it.new_value = nv;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        sb.note_item(it);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready pattern, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int burst;
        int gap;
        out_ready <= 1'b0;
        forever begin
            if (hold_now) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_now = 1'b0;
            end else begin
                burst = $urandom_range(1, 20);
                out_ready <= 1'b1;
                repeat (burst) @(posedge clk);
                gap = pick_gap();
                if (gap > 0) begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    // output monitor: a beat moves when valid and ready meet at the edge
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_beat(out_data);
    end

    // watchdog on cycles where neither side moves a beat
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int  r;
        bit  grow;
        logic [2:0] f;

        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        hold_now = 1'b0;
        calm     = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        // empty list: read, sort, delete and modify all report a status
        send_op(FUNC_READ,   '0, '0);
        send_op(FUNC_SORT,   '0, '0);
        send_op(FUNC_DELETE, VAL_MIN, '0);
        send_op(FUNC_MODIFY, '0, VAL_MAX);
        // one element is too few to sort
        send_op(FUNC_APPEND, VAL_MIN, '0);
        send_op(FUNC_SORT,   '0, '0);
        send_op(FUNC_APPEND, VAL_MAX, '0);
        send_op(FUNC_APPEND, -32'sd1, '0);
        send_op(FUNC_APPEND, '0, '0);
        // fill up with duplicates of -2..1
        for (int k = 0; k < Capacity - 4; k++) send_op(FUNC_APPEND, 32'(k % 4) - 32'd2, '0);
        // append to a full list is dropped
        send_op(FUNC_APPEND, 32'sd77, '0);
        // first-match rules on duplicates, then the no-match cases
        send_op(FUNC_MODIFY, -32'sd1, VAL_MIN);
        send_op(FUNC_DELETE, '0, '0);
        send_op(FUNC_DELETE, 32'sd12345, '0);
        send_op(FUNC_MODIFY, 32'sd12345, 32'sd1);
        send_op(FUNC_SORT,   '0, '0);
        send_op(FUNC_READ,   '0, '0);
        send_op(FUNC_SPARE6, VAL_MAX, VAL_MIN);
        send_op(FUNC_SPARE7, -32'sd1, -32'sd1);
        send_op(FUNC_CLEAR,  '0, '0);
        send_op(FUNC_READ,   '0, '0);

        // --- random ---
        // alternate growth and churn phases so the list swings from empty to full
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == 30 || n == 130) hold_now = 1'b1;
            calm = (n >= 80 && n < 100);
            grow = ((n / 30) % 2) == 0;
            r    = $urandom_range(0, 99);
            if (grow) begin
                if      (r < 55) f = FUNC_APPEND;
                else if (r < 65) f = FUNC_DELETE;
                else if (r < 75) f = FUNC_MODIFY;
                else if (r < 83) f = FUNC_SORT;
                else if (r < 93) f = FUNC_READ;
                else if (r < 95) f = FUNC_CLEAR;
                else if (r < 97) f = FUNC_SPARE6;
                else             f = FUNC_SPARE7;
            end else begin
                if      (r < 30) f = FUNC_APPEND;
                else if (r < 50) f = FUNC_DELETE;
                else if (r < 65) f = FUNC_MODIFY;
                else if (r < 75) f = FUNC_SORT;
                else if (r < 90) f = FUNC_READ;
                else if (r < 95) f = FUNC_CLEAR;
                else if (r < 97) f = FUNC_SPARE6;
                else             f = FUNC_SPARE7;
            end
            if (f == FUNC_DELETE || f == FUNC_MODIFY) send_op(f, list_value(), rand_value());
            else send_op(f, rand_value(), rand_value());
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        // let every expected beat arrive, then watch for strays
        while (sb.expected_beats.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
sv/olst_pkg.sv
sv/olst_cell.sv
sv/olst_chain.sv
sv/ordered_list_store_top.sv
dv/tb_ordered_list_store_top.sv
